@@ sv/slpd_pkg.sv @@
package slpd_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int CLASS_W   = 3;
    localparam int SECTION_W = 2;
    localparam int PHASE_W   = 4;

    // Packed stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = CLASS_W;
    localparam int M_USED_W  = SECTION_W + 4 * BYTE_W - BYTE_W + 1;

    localparam logic [BYTE_W-1:0] FIXED_AREA_LENGTH_RESET = 8'd115;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    // Parse phases; even phases 2..6 expect a length, odd 3..7 a body byte
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_FIXED    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ANT_LEN  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BAND_LEN = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;

    // Byte classes
    localparam logic [CLASS_W-1:0] CL_IGNORED = 3'd0;
    localparam logic [CLASS_W-1:0] CL_FIXED   = 3'd1;
    localparam logic [CLASS_W-1:0] CL_LENGTH  = 3'd2;
    localparam logic [CLASS_W-1:0] CL_BODY    = 3'd3;
    localparam logic [CLASS_W-1:0] CL_END     = 3'd4;
    localparam logic [CLASS_W-1:0] CL_STARTED = 3'd5;
    localparam logic [CLASS_W-1:0] CL_REFUSED = 3'd6;
    localparam logic [CLASS_W-1:0] CL_ABORTED = 3'd7;

    localparam logic [SECTION_W-1:0] SEC_BAND = 2'd3;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  remaining;
        logic [BYTE_W-1:0]  position;
        logic [BYTE_W-1:0]  count;
    } parse_state_t;

    typedef struct packed {
        logic [CLASS_W-1:0]   byte_class;
        logic [SECTION_W-1:0] section;
        logic [BYTE_W-1:0]    record_index;
        logic [BYTE_W-1:0]    byte_offset;
        logic                 record_last;
        logic                 dump_done;
        logic [BYTE_W-1:0]    data_out;
    } parse_result_t;

endpackage

@@ sv/slpd_parser.sv @@
module slpd_parser
    import slpd_pkg::*;
(
    input  parse_state_t        cur_state,
    input  logic [KIND_W-1:0]   kind,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [BYTE_W-1:0]   fixed_area_length,
    output parse_state_t        state_next,
    output parse_result_t       result
);

    logic              busy;
    logic [BYTE_W-1:0] rem_dec;
    logic [BYTE_W-1:0] pos_inc;

    assign busy    = (cur_state.phase >= PH_FIXED) && (cur_state.phase < PH_DONE);
    assign rem_dec = cur_state.remaining - 8'd1;
    assign pos_inc = cur_state.position + 8'd1;

    // Per-item decision and state update
    always_comb
    begin
        state_next = cur_state;
        result     = '0;
        case (kind)
            KIND_START:
            begin
                if (busy)
                begin
                    result.byte_class = CL_REFUSED;
                end
                else
                begin
                    result.byte_class    = CL_STARTED;
                    state_next.remaining = fixed_area_length;
                    state_next.position  = '0;
                    state_next.count     = '0;
                    state_next.phase     = (fixed_area_length != '0) ? PH_FIXED : PH_ANT_LEN;
                end
            end
            KIND_ABORT:
            begin
                result.byte_class = CL_ABORTED;
                state_next        = '0;
            end
            KIND_DATA:
            begin
                result.data_out = data_byte;
                if (cur_state.phase == PH_FIXED)
                begin
                    result.byte_class    = CL_FIXED;
                    result.byte_offset   = cur_state.position;
                    result.record_last   = (cur_state.remaining <= 8'd1);
                    state_next.position  = pos_inc;
                    state_next.remaining = rem_dec;
                    if (rem_dec == '0)
                    begin
                        state_next       = '0;
                        state_next.phase = PH_ANT_LEN;
                    end
                end
                else if (busy)
                begin
                    result.section      = cur_state.phase[2:1];
                    result.record_index = cur_state.count;
                    if (!cur_state.phase[0])
                    begin
                        // length prefix or section terminator
                        if (data_byte != '0)
                        begin
                            result.byte_class    = CL_LENGTH;
                            state_next.remaining = data_byte;
                            state_next.position  = '0;
                            state_next.phase     = cur_state.phase + 4'd1;
                        end
                        else
                        begin
                            result.byte_class = CL_END;
                            state_next        = '0;
                            if (cur_state.phase == PH_BAND_LEN)
                            begin
                                result.dump_done = 1'b1;
                                state_next.phase = PH_DONE;
                            end
                            else
                            begin
                                state_next.phase = cur_state.phase + 4'd2;
                            end
                        end
                    end
                    else
                    begin
                        // record body byte
                        result.byte_class    = CL_BODY;
                        result.byte_offset   = cur_state.position;
                        result.record_last   = (cur_state.remaining <= 8'd1);
                        state_next.position  = pos_inc;
                        state_next.remaining = rem_dec;
                        if (rem_dec == '0)
                        begin
                            state_next.position = '0;
                            if (cur_state.count != 8'hFF)
                            begin
                                state_next.count = cur_state.count + 8'd1;
                            end
                            state_next.phase = cur_state.phase - 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                result.byte_class = CL_IGNORED;
            end
        endcase
    end

endmodule

@@ sv/sectioned_length_prefixed_deframer_unit.sv @@
// Channel  Dir  Signals                        Contents
// s_axis   in   tvalid tready tdata tuser      data_byte; kind
// m_axis   out  tvalid tready tdata tuser tlast tagged byte; byte_class; record_last
// cfg      in   cfg_wr_en cfg_wr_data          fixed_area_length
//
// One item per cycle sustained while m_axis_tready is high; each item passes the input then the output register.
// An input register feeds the parser; its result and the new parse state load together.
// The input register keeps taking one item while a result waits on m_axis_tready.
// rst_n clears the parse state to idle and fixed_area_length to 115; no clearing pass.
module sectioned_length_prefixed_deframer_unit
    import slpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [1:0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] section, [9:2] record_index, [17:10] byte_offset, [18] dump_done,
    // [26:19] data_out, [31:27] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // [2:0] byte_class
    output logic                 m_axis_tlast,   // record_last
    input  logic                 cfg_wr_en,
    input  logic [BYTE_W-1:0]    cfg_wr_data
);

    logic              in_valid_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              out_valid_reg;
    parse_result_t     out_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    parse_result_t     result_next;
    logic [BYTE_W-1:0] fixed_len_reg;
    logic              out_free;
    logic              advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    slpd_parser u_parser (
        .cur_state         (state_reg),
        .kind              (in_kind_reg),
        .data_byte         (in_data_reg),
        .fixed_area_length (fixed_len_reg),
        .state_next        (state_next),
        .result            (result_next)
    );

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            fixed_len_reg <= FIXED_AREA_LENGTH_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                fixed_len_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.byte_class;
    assign m_axis_tlast  = out_reg.record_last;
    assign m_axis_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, out_reg.data_out,
                            out_reg.dump_done, out_reg.byte_offset,
                            out_reg.record_index, out_reg.section};

    // Abort always leaves the parser idle with cleared counters
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_kind_reg == KIND_ABORT |=> state_reg == '0)
        else $error("abort did not clear parse state");

    // Dump completion only on a band section terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.dump_done |->
            out_reg.byte_class == CL_END && out_reg.section == SEC_BAND)
        else $error("dump_done outside band terminator");

    // Input side stalls only when both stages are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without backpressure");

    // Record count is nonzero only inside a record section
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count != '0 |->
            state_reg.phase >= PH_ANT_LEN && state_reg.phase < PH_DONE)
        else $error("record count outside record sections");

    // Parse phase never leaves its defined range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_DONE)
        else $error("parse phase out of range");

endmodule
